// ----- rtl/core/circular_deque_defines.svh -----
// assertion macros for the circular deque
// no dependencies; included by the top level, which supplies clk and rst
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked property, masked while reset is high
`define CDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// checked implication, masked while reset is high
`define CDQ_ASSERT_IMPL(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
`else
`define CDQ_ASSERT(lbl, prop, msg)
`define CDQ_ASSERT_IMPL(lbl, cond, prop, msg)
`endif

`endif

// ----- rtl/core/cdq_pkg.sv -----
// shared types and codes for the circular deque
// no dependencies; imported by the controller, datapath, top level, checker and bench top
`default_nettype none

package cdq_pkg;

  // request opcodes
  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_REAR   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } opcode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // datapath operation chosen by the controller
  typedef enum logic [2:0] {
    DP_NONE,
    DP_PUSH_FIRST,
    DP_PUSH_REAR,
    DP_PUSH_FRONT,
    DP_POP_LAST,
    DP_POP_REAR,
    DP_POP_FRONT
  } dp_op_t;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 8;

  // controller to datapath
  typedef struct packed {
    logic    load;    // request taken this cycle
    dp_op_t  op;
    status_t status;
  } cdq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic single;
  } cdq_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/cdq_ctrl.sv -----
// controller for the circular deque: handshake state machine and op decode
// depends on cdq_pkg
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire opcode_t   opcode,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire cdq_stat_t stat,
  output cdq_cmd_t       cmd
);

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  state_t state;
  logic   take;

  assign take = in_ready && in_valid;

  // decide the datapath operation from the opcode and the fill status
  always_comb begin
    cmd.load   = take;
    cmd.op     = DP_NONE;
    cmd.status = ST_OK;
    case (opcode)
      OP_PUSH_REAR, OP_PUSH_FRONT: begin
        if (stat.full) begin
          cmd.status = ST_OVERFLOW;
        end else if (stat.empty) begin
          cmd.op = DP_PUSH_FIRST;
        end else if (opcode == OP_PUSH_REAR) begin
          cmd.op = DP_PUSH_REAR;
        end else begin
          cmd.op = DP_PUSH_FRONT;
        end
      end
      OP_POP_REAR, OP_POP_FRONT: begin
        if (stat.empty) begin
          cmd.status = ST_UNDERFLOW;
        end else if (stat.single) begin
          cmd.op = DP_POP_LAST;
        end else if (opcode == OP_POP_REAR) begin
          cmd.op = DP_POP_REAR;
        end else begin
          cmd.op = DP_POP_FRONT;
        end
      end
      default: begin
        cmd.op = DP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            state     <= S_RESP;
            in_ready  <= 1'b0;
            out_valid <= 1'b1;
          end
        end
        S_RESP: begin
          if (out_ready) begin
            state     <= S_IDLE;
            in_ready  <= 1'b1;
            out_valid <= 1'b0;
          end
        end
        default: begin
          state     <= S_IDLE;
          in_ready  <= 1'b1;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cdq_datapath.sv -----
// datapath for the circular deque: store, front/rear indexes, count, result
// depends on cdq_pkg
`default_nettype none

module cdq_datapath
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cdq_cmd_t           cmd,
  input  wire logic [VALUE_W-1:0] push_value,
  output cdq_stat_t               stat,
  output logic [VALUE_W-1:0]      pop_value,
  output status_t                 status,
  output logic [COUNT_W-1:0]      entry_count
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data;
  logic [IDX_W-1:0]   front;
  logic [IDX_W-1:0]   rear;
  logic [CNT_W-1:0]   count;
  logic               pop_ok;
  status_t            res_status;

  logic [IDX_W-1:0]   rear_inc;
  logic [IDX_W-1:0]   rear_dec;
  logic [IDX_W-1:0]   front_inc;
  logic [IDX_W-1:0]   front_dec;
  logic               we;
  logic               re;
  logic [IDX_W-1:0]   waddr;
  logic [IDX_W-1:0]   raddr;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  // wrap by compare so any depth works
  assign rear_inc  = (rear == LAST_IDX) ? '0 : rear + 1'b1;
  assign rear_dec  = (rear == '0) ? LAST_IDX : rear - 1'b1;
  assign front_inc = (front == LAST_IDX) ? '0 : front + 1'b1;
  assign front_dec = (front == '0) ? LAST_IDX : front - 1'b1;

  assign stat.empty  = (count == '0);
  assign stat.full   = (count == FULL_CNT);
  assign stat.single = (count == CNT_W'(1));

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = front;
    if (cmd.load) begin
      case (cmd.op)
        DP_PUSH_FIRST: begin
          we = 1'b1;
        end
        DP_PUSH_REAR: begin
          we    = 1'b1;
          waddr = rear_inc;
        end
        DP_PUSH_FRONT: begin
          we    = 1'b1;
          waddr = front_dec;
        end
        DP_POP_LAST, DP_POP_FRONT: begin
          re = 1'b1;
        end
        DP_POP_REAR: begin
          re    = 1'b1;
          raddr = rear;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  // store: one write or one registered read per request
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= push_value;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front      <= '0;
      rear       <= '0;
      count      <= '0;
      pop_ok     <= 1'b0;
      res_status <= ST_OK;
    end else if (cmd.load) begin
      res_status <= cmd.status;
      pop_ok     <= re;
      case (cmd.op)
        DP_PUSH_FIRST: begin
          front <= '0;
          rear  <= '0;
          count <= CNT_W'(1);
        end
        DP_PUSH_REAR: begin
          rear  <= rear_inc;
          count <= count + 1'b1;
        end
        DP_PUSH_FRONT: begin
          front <= front_dec;
          count <= count + 1'b1;
        end
        DP_POP_LAST: begin
          front <= '0;
          rear  <= '0;
          count <= '0;
        end
        DP_POP_REAR: begin
          rear  <= rear_dec;
          count <= count - 1'b1;
        end
        DP_POP_FRONT: begin
          front <= front_inc;
          count <= count - 1'b1;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  assign count_ext   = {{COUNT_W{1'b0}}, count};
  assign entry_count = count_ext[COUNT_W-1:0];
  assign pop_value   = pop_ok ? rd_data : '0;
  assign status      = res_status;

endmodule

`default_nettype wire

// ----- rtl/core/circular_deque.sv -----
// top level of the circular deque: stream ports, controller and datapath
// depends on cdq_pkg, cdq_ctrl, cdq_datapath and circular_deque_defines.svh
//
//   channel   dir   tdata / tuser contents (lowest bit first)
//   s_*       in    tdata: push_value[31:0]; tuser: opcode[1:0]
//   m_*       out   tdata: pop_value[31:0], status[33:32], entry_count[41:34], zero[47:42]
//
// one request at a time: a taken request shows its result the next cycle
// and s_tready returns the cycle after m_tready takes it, so a new request
// is not taken until the previous result has been taken
// the store has one write port and one registered read port; a pop reads
// it at the taken edge and the result register holds until taken
// rst is synchronous; after it the deque is empty and s_tready is high
// the store has no reset; only written entries are ever read
`default_nettype none
`include "circular_deque_defines.svh"

module circular_deque
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // push_value[31:0]
  input  wire logic [1:0]  s_tuser,   // opcode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // pop_value[31:0], status[33:32], entry_count[41:34]
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W+COUNT_W-1:0] FULL_EXT = (CNT_W + COUNT_W)'(DEPTH);
  localparam logic [COUNT_W-1:0] FULL_CNT8 = FULL_EXT[COUNT_W-1:0];

  cdq_cmd_t           cmd;
  cdq_stat_t          stat;
  logic [VALUE_W-1:0] pop_value;
  status_t            status;
  logic [COUNT_W-1:0] entry_count;

  // state machine: handshakes and op decode
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .opcode    (opcode_t'(s_tuser)),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // store, indexes and result registers
  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .push_value  (s_tdata),
    .stat        (stat),
    .pop_value   (pop_value),
    .status      (status),
    .entry_count (entry_count)
  );

  assign m_tdata = {6'b0, entry_count, status, pop_value};

  // never ready for a request while a result is pending
  `CDQ_ASSERT(a_one_in_flight, !(s_tready && m_tvalid), "request taken while result pending")
  // a taken request shows its result on the next cycle
  `CDQ_ASSERT_IMPL(a_result_next, s_tvalid && s_tready, ##1 m_tvalid, "result missing after request")
  // a refused push only happens on a full deque
  `CDQ_ASSERT_IMPL(a_overflow_full, m_tvalid && (m_tdata[33:32] == ST_OVERFLOW), m_tdata[41:34] == FULL_CNT8, "overflow on a deque that is not full")
  // a refused pop leaves an empty deque and returns zero
  `CDQ_ASSERT_IMPL(a_underflow_empty, m_tvalid && (m_tdata[33:32] == ST_UNDERFLOW), (m_tdata[41:34] == '0) && (m_tdata[31:0] == '0), "underflow with entries held or nonzero value")

endmodule

`default_nettype wire

// ----- bench/deque_checker.sv -----
// result checker for the circular deque: watches both stream channels
// keeps its own model of the deque and compares every result; needs cdq_pkg
`timescale 1ns / 100ps

module deque_checker
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,    // push_value[31:0]
  input  logic [1:0]  s_tuser,    // opcode[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,    // pop_value[31:0], status[33:32], entry_count[41:34]
  output int          fail_count,
  output int          req_count,
  output int          rsp_count
);

  typedef struct packed {
    logic [VALUE_W-1:0] pop_value;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } deque_rsp_t;

  deque_rsp_t  expected_rsps[$];
  logic [31:0] slots [DEPTH];
  int unsigned head_idx;
  int unsigned tail_idx;
  logic        deque_empty;
  int          errs = 0;

  assign fail_count = errs;

  function automatic logic deque_full();
    return !deque_empty && head_idx == (tail_idx + 1) % DEPTH;
  endfunction

  function automatic logic [COUNT_W-1:0] held_entries();
    if (deque_empty) return '0;
    return COUNT_W'(((tail_idx + DEPTH - head_idx) % DEPTH) + 1);
  endfunction

  // one request against the model; updates the model state
  function automatic deque_rsp_t apply_request(opcode_t op, logic [31:0] val);
    deque_rsp_t r;
    r.pop_value = '0;
    r.status    = ST_OK;
    case (op)
      OP_PUSH_REAR, OP_PUSH_FRONT: begin
        if (deque_full()) begin
          r.status = ST_OVERFLOW;
        end else if (deque_empty) begin
          head_idx    = 0;
          tail_idx    = 0;
          slots[0]    = val;
          deque_empty = 1'b0;
        end else if (op == OP_PUSH_REAR) begin
          tail_idx        = (tail_idx + 1) % DEPTH;
          slots[tail_idx] = val;
        end else begin
          head_idx        = (head_idx + DEPTH - 1) % DEPTH;
          slots[head_idx] = val;
        end
      end
      default: begin
        if (deque_empty) begin
          r.status = ST_UNDERFLOW;
        end else if (head_idx == tail_idx) begin
          r.pop_value = slots[head_idx];
          head_idx    = 0;
          tail_idx    = 0;
          deque_empty = 1'b1;
        end else if (op == OP_POP_REAR) begin
          r.pop_value = slots[tail_idx];
          tail_idx    = (tail_idx + DEPTH - 1) % DEPTH;
        end else begin
          r.pop_value = slots[head_idx];
          head_idx    = (head_idx + 1) % DEPTH;
        end
      end
    endcase
    r.count = held_entries();
    return r;
  endfunction

  always @(posedge clk) begin : watch
    deque_rsp_t exp_r;
    if (rst) begin
      head_idx    = 0;
      tail_idx    = 0;
      deque_empty = 1'b1;
      expected_rsps.delete();
      req_count <= 0;
      rsp_count <= 0;
    end else begin
      // results first: a result taken now belongs to an older request
      if (m_tvalid && m_tready) begin
        rsp_count <= rsp_count + 1;
        if (expected_rsps.size() == 0) begin
          $error("unexpected result, tdata %h", m_tdata);
          errs++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (m_tdata[31:0] !== exp_r.pop_value) begin
            $error("pop_value: expected %h, got %h", exp_r.pop_value, m_tdata[31:0]);
            errs++;
          end
          if (m_tdata[33:32] !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, m_tdata[33:32]);
            errs++;
          end
          if (m_tdata[41:34] !== exp_r.count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.count, m_tdata[41:34]);
            errs++;
          end
          if (m_tdata[47:42] !== 6'd0) begin
            $error("padding: expected 0, got %h", m_tdata[47:42]);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        req_count <= req_count + 1;
        expected_rsps.push_back(apply_request(opcode_t'(s_tuser), s_tdata));
      end
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// top of the circular deque testbench: clock, reset, request and result drivers
// depends on cdq_pkg, circular_deque and deque_checker
`timescale 1ns / 100ps

module tb_top;
  import cdq_pkg::*;

  localparam int unsigned DEPTH = 128;
  localparam int LIMIT = 200000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [47:0] m_tdata;

  int fail_count;
  int req_count;
  int rsp_count;
  int cycles = 0;

  // push mix per random phase, in percent, and requests per phase
  int push_pct [6] = '{50, 92, 50, 8, 60, 10};
  int phase_len[6] = '{40, 170, 40, 170, 20, 20};

  circular_deque #(.DEPTH(DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  deque_checker #(.DEPTH(DEPTH)) i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .req_count  (req_count),
    .rsp_count  (rsp_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic opcode_t pick_op(int pct);
    logic side;
    side = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < pct) return side ? OP_PUSH_FRONT : OP_PUSH_REAR;
    return side ? OP_POP_FRONT : OP_POP_REAR;
  endfunction

  // offer one request, hold it until taken, then idle for the requested gap
  task automatic send_req(opcode_t op, logic [31:0] val, int gap);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender stays quiet until every request has its result
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (req_count != rsp_count) @(posedge clk);
  endtask

  // result side: random stalls, ready runs, and one long hold-off
  initial begin : result_side
    int rx_cycle;
    int hold;
    int run;
    rx_cycle = 0;
    hold     = 0;
    run      = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      // long hold-off while the sender keeps offering, so input stalls
      if (rx_cycle == 600) hold = 300;
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else if (run > 0) begin
        m_tready <= 1'b1;
        run--;
      end else if ($urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        hold = pick_gap();
      end else begin
        m_tready <= 1'b1;
        run = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(10, 40);
      end
    end
  end

  initial begin : request_side
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pops on an empty deque are refused
    send_req(OP_POP_REAR, 32'hFFFF_FFFF, pick_gap());
    send_req(OP_POP_FRONT, 32'h0000_0000, pick_gap());
    // push into empty, then pop the last entry, both ends
    send_req(OP_PUSH_REAR, 32'h7FFF_FFFF, pick_gap());
    send_req(OP_POP_FRONT, $urandom, pick_gap());
    send_req(OP_PUSH_FRONT, 32'h8000_0000, pick_gap());
    send_req(OP_POP_REAR, $urandom, pick_gap());
    // front push wraps the head index below zero
    send_req(OP_PUSH_REAR, 32'h0000_0000, pick_gap());
    send_req(OP_PUSH_REAR, 32'hFFFF_FFFF, pick_gap());
    send_req(OP_PUSH_FRONT, 32'h5555_5555, pick_gap());
    send_req(OP_PUSH_FRONT, 32'hAAAA_AAAA, pick_gap());
    send_req(OP_POP_REAR, $urandom, pick_gap());
    send_req(OP_POP_FRONT, $urandom, pick_gap());
    send_req(OP_POP_REAR, $urandom, pick_gap());
    send_req(OP_POP_FRONT, $urandom, pick_gap());
    send_req(OP_POP_FRONT, $urandom, pick_gap());
    send_req(OP_PUSH_FRONT, 32'h8000_0001, pick_gap());
    send_req(OP_PUSH_REAR, 32'h7FFF_FFFE, pick_gap());
    send_req(OP_POP_REAR, $urandom, pick_gap());
    send_req(OP_POP_REAR, $urandom, pick_gap());
    send_req(OP_POP_REAR, $urandom, pick_gap());
    wait_drained();

    // random phases: fill to overflow, drain to underflow, mixed between
    for (int p = 0; p < 6; p++) begin
      for (int n = 0; n < phase_len[p]; n++) begin
        send_req(pick_op(push_pct[p]), $urandom, pick_gap());
      end
      wait_drained();
    end

    // let any late result show before the verdict
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/cdq_pkg.sv
rtl/core/cdq_ctrl.sv
rtl/core/cdq_datapath.sv
rtl/core/circular_deque.sv
bench/deque_checker.sv
bench/tb_top.sv
